/* rtl/rgd_pkg.sv */
// rgd_pkg: shared types and constants of the rds group decoder
// holds the command item passed from the front classifier to the back executor
// no dependencies
package rgd_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  CODE_LOW     = 8'h0A;
    localparam logic [3:0]  TYPE_NAME    = 4'h0;
    localparam logic [3:0]  TYPE_TEXT    = 4'h2;
    localparam logic [7:0]  CHAR_DASH    = 8'h2D;
    localparam logic [63:0] NAME_SPACES  = 64'h2020_2020_2020_2020;
    localparam logic [15:0] PAIR_DASHES  = {CHAR_DASH, CHAR_DASH};
    localparam logic [1:0]  LAST_SEGMENT = 2'd3;

    typedef enum logic [1:0] {
        KIND_RESET,
        KIND_NAME,
        KIND_TEXT,
        KIND_OTHER
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  code;
        logic [3:0]  slot;
        logic        flag;
        logic [15:0] chars_c;
        logic [15:0] chars_d;
    } cmd_t;

endpackage

/* rtl/rgd_front.sv */
// rgd_front: accepts groups and classifies them into command items
// depends on rgd_pkg
module rgd_front
    import rgd_pkg::*;
(
    input  logic        grp_valid,
    input  logic [15:0] block_a,
    input  logic [15:0] block_b,
    input  logic [15:0] block_c,
    input  logic [15:0] block_d,
    input  logic        queue_full,
    output logic        grp_stall,
    output logic        push,
    output cmd_t        cmd
);

    logic [7:0] code;

    // type nibble high, version bit low, ored with 0x0a
    assign code = {block_b[15:12], CODE_LOW[3:1], block_b[11]};

    always_comb
    begin
        cmd.code    = code;
        cmd.slot    = block_b[3:0];
        cmd.flag    = block_b[4];
        cmd.chars_c = block_c;
        cmd.chars_d = block_d;
        if (block_a == 16'd0)
        begin
            cmd.kind = KIND_RESET;
            cmd.code = 8'd0;
        end
        else if (block_b[15:12] == TYPE_NAME)
        begin
            cmd.kind = KIND_NAME;
        end
        else if (block_b[15:12] == TYPE_TEXT && !block_b[11])
        begin
            cmd.kind = KIND_TEXT;
        end
        else
        begin
            cmd.kind = KIND_OTHER;
        end
    end

    assign grp_stall = queue_full;
    assign push      = grp_valid && !queue_full;

endmodule

/* rtl/rgd_queue.sv */
// rgd_queue: short command queue between front and back
// depends on rgd_pkg
module rgd_queue
    import rgd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_next;

    assign full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

/* rtl/rgd_back.sv */
// rgd_back: executes command items against the name and text-flag stores
// and holds the result register; depends on rgd_pkg
module rgd_back
    import rgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  cmd_t        head,
    output logic        pop,
    input  logic        res_stall,
    output logic        res_valid,
    output logic [7:0]  group_code,
    output logic [63:0] station_name,
    output logic        name_changed,
    output logic        was_reset,
    output logic        text_cleared,
    output logic        text_written,
    output logic [3:0]  text_slot,
    output logic [31:0] text_chars
);

    // name stores as four character pairs, pair 0 is the first two characters
    logic [15:0] cand_reg [4];
    logic [15:0] conf_reg [4];
    logic [15:0] cand_next [4];
    logic [15:0] conf_next [4];
    logic [63:0] pub_reg;
    logic [63:0] pub_next;
    logic        flag_reg;
    logic        flag_next;

    logic        res_valid_reg;
    logic [7:0]  code_reg;
    logic        changed_reg;
    logic        reset_reg;
    logic        cleared_reg;
    logic        written_reg;
    logic [3:0]  slot_reg;
    logic [31:0] chars_reg;

    logic        changed_next;
    logic        cleared_next;
    logic        pair_match;
    logic [1:0]  seg;
    logic [63:0] cand_packed;
    logic [63:0] conf_packed;

    assign pop = !empty && (!res_valid_reg || !res_stall);
    assign seg = head.slot[1:0];

    assign pair_match  = (cand_reg[seg] == head.chars_d);
    assign cand_packed = {cand_reg[0], cand_reg[1], cand_reg[2], cand_reg[3]};
    assign conf_packed = {conf_next[0], conf_next[1], conf_next[2], conf_next[3]};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cand_next[i] = cand_reg[i];
            conf_next[i] = conf_reg[i];
        end
        pub_next     = pub_reg;
        flag_next    = flag_reg;
        changed_next = 1'b0;
        cleared_next = 1'b0;
        case (head.kind)
            KIND_RESET:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    cand_next[i] = PAIR_DASHES;
                    conf_next[i] = PAIR_DASHES;
                end
                pub_next     = NAME_SPACES;
                cleared_next = 1'b1;
            end
            KIND_NAME:
            begin
                if (pair_match)
                begin
                    conf_next[seg] = head.chars_d;
                end
                // candidate still holds the pair here, so the full compare is valid
                if (pair_match && seg == LAST_SEGMENT && cand_packed == conf_packed
                    && conf_packed != pub_reg)
                begin
                    pub_next     = conf_packed;
                    changed_next = 1'b1;
                end
                cand_next[seg] = head.chars_d;
            end
            KIND_TEXT:
            begin
                if (head.flag != flag_reg)
                begin
                    flag_next    = head.flag;
                    cleared_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cand_reg[i] <= PAIR_DASHES;
                conf_reg[i] <= PAIR_DASHES;
            end
            pub_reg       <= NAME_SPACES;
            flag_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    cand_reg[i] <= cand_next[i];
                    conf_reg[i] <= conf_next[i];
                end
                pub_reg  <= pub_next;
                flag_reg <= flag_next;
            end
            if (pop)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            code_reg    <= head.code;
            changed_reg <= changed_next;
            reset_reg   <= (head.kind == KIND_RESET);
            cleared_reg <= cleared_next;
            written_reg <= (head.kind == KIND_TEXT);
            slot_reg    <= (head.kind == KIND_TEXT) ? head.slot : 4'd0;
            chars_reg   <= (head.kind == KIND_TEXT) ? {head.chars_c, head.chars_d} : 32'd0;
        end
    end

    assign res_valid    = res_valid_reg;
    assign group_code   = code_reg;
    assign station_name = pub_reg;
    assign name_changed = changed_reg;
    assign was_reset    = reset_reg;
    assign text_cleared = cleared_reg;
    assign text_written = written_reg;
    assign text_slot    = slot_reg;
    assign text_chars   = chars_reg;

    a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && reset_reg |-> cleared_reg && pub_reg == NAME_SPACES)
        else $error("reset item without cleared text or space name");

    a_change_name_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && changed_reg |-> !reset_reg && !written_reg
        && code_reg[7:4] == TYPE_NAME)
        else $error("name change from a non-name item");

    a_pub_moves_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.kind != KIND_RESET && !changed_next |=> $stable(pub_reg))
        else $error("published name moved without a change");

endmodule

/* rtl/rds_group_decoder.sv */
// rds_group_decoder: top level of the rds group decoder
// depends on rgd_pkg, rgd_front, rgd_queue, rgd_back
//
// takes one rds group (four 16-bit blocks) per item and returns exactly one result
// item per group. a zero first block resets the station-name stores to dashes,
// the published name to spaces, and flags a text clear. groups 0a/0b carry two
// name characters at segment block_b[1:0]; a pair seen twice in a row is
// confirmed, and when the last segment confirms with candidate and confirmed
// names equal in all eight bytes the name is published (name_changed marks a new
// value). group 2a reports four radiotext characters for slot block_b[3:0]; the
// text buffer itself lives outside, and text_cleared tells it to clear on an
// a/b flag toggle. rate: one item per cycle while res_stall is low; the front
// classifies each accepted group into a two-entry queue, then the back executor
// pops it, updates the stores and loads the result register. the result register
// and queue let a new group be accepted while a result waits.
// there is no clearing pass; the stores come out of reset ready.
module rds_group_decoder
    import rgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // group channel
    input  logic        grp_valid,
    output logic        grp_stall,
    input  logic [15:0] block_a,
    input  logic [15:0] block_b,
    input  logic [15:0] block_c,
    input  logic [15:0] block_d,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  group_code,
    output logic [63:0] station_name,
    output logic        name_changed,
    output logic        was_reset,
    output logic        text_cleared,
    output logic        text_written,
    output logic [3:0]  text_slot,
    output logic [31:0] text_chars
);

    // front to queue
    logic push;
    cmd_t push_cmd;
    logic queue_full;

    // queue to back
    logic pop;
    logic queue_empty;
    cmd_t head_cmd;

    // classify the group: reset, name, text or other
    rgd_front u_front (
        .grp_valid  (grp_valid),
        .block_a    (block_a),
        .block_b    (block_b),
        .block_c    (block_c),
        .block_d    (block_d),
        .queue_full (queue_full),
        .grp_stall  (grp_stall),
        .push       (push),
        .cmd        (push_cmd)
    );

    // decouples acceptance from result backpressure
    rgd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (queue_full),
        .empty    (queue_empty),
        .head     (head_cmd)
    );

    // store updates and result register
    rgd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (queue_empty),
        .head         (head_cmd),
        .pop          (pop),
        .res_stall    (res_stall),
        .res_valid    (res_valid),
        .group_code   (group_code),
        .station_name (station_name),
        .name_changed (name_changed),
        .was_reset    (was_reset),
        .text_cleared (text_cleared),
        .text_written (text_written),
        .text_slot    (text_slot),
        .text_chars   (text_chars)
    );

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for the rds group decoder
// depends on rgd_pkg for the group type codes and the name store constants
// a driver and a monitor run as clocked processes against a built-in decode predictor
`timescale 1ns / 100ps

module tb;
    import rgd_pkg::*;

    localparam int GROUP_COUNT = 2000;
    localparam int CALM_TAIL   = 150;      // no idling over the last items of the run
    localparam int HOLD_AT     = 400;      // results seen before the long receiver hold
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;   // far beyond the slowest correct run

    // one rds group as offered on the input channel
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
    } rds_group_t;

    // one decoded result as seen on the output channel
    typedef struct packed {
        logic [7:0]  code;
        logic [63:0] name;
        logic        changed;
        logic        reset;
        logic        cleared;
        logic        written;
        logic [3:0]  slot;
        logic [31:0] chars;
    } decoded_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        grp_valid = 1'b0;
    logic        grp_stall;
    logic [15:0] block_a = '0;
    logic [15:0] block_b = '0;
    logic [15:0] block_c = '0;
    logic [15:0] block_d = '0;

    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [7:0]  group_code;
    logic [63:0] station_name;
    logic        name_changed;
    logic        was_reset;
    logic        text_cleared;
    logic        text_written;
    logic [3:0]  text_slot;
    logic [31:0] text_chars;

    rds_group_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .grp_valid    (grp_valid),
        .grp_stall    (grp_stall),
        .block_a      (block_a),
        .block_b      (block_b),
        .block_c      (block_c),
        .block_d      (block_d),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .group_code   (group_code),
        .station_name (station_name),
        .name_changed (name_changed),
        .was_reset    (was_reset),
        .text_cleared (text_cleared),
        .text_written (text_written),
        .text_slot    (text_slot),
        .text_chars   (text_chars)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the decoder stores
    logic [7:0]  cand_name [8];
    logic [7:0]  conf_name [8];
    logic [63:0] pub_name;
    logic        text_flag;

    rds_group_t group_backlog [$];     // groups still to be offered
    decoded_t   decoded_due [$];       // predicted results not yet seen

    int total_groups = 0;
    int accepted     = 0;              // groups taken by the block
    int results_seen = 0;
    int faults       = 0;
    int cycles       = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    logic stim_flag  = 1'b0;           // a/b flag the stimulus is currently using

    // ------------------------------------------------------------------
    // predictor: decodes one group and updates the name stores
    // ------------------------------------------------------------------
    function automatic decoded_t decode_group(input rds_group_t g);
        decoded_t    r;
        logic [2:0]  pos;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic        same;
        logic [63:0] packed_name;
        r = '0;
        if (g.a == 16'h0000)
        begin
            // zero pi code wipes the name stores, the text flag survives
            for (int i = 0; i < 8; i++)
            begin
                cand_name[i] = CHAR_DASH;
                conf_name[i] = CHAR_DASH;
            end
            pub_name  = NAME_SPACES;
            r.reset   = 1'b1;
            r.cleared = 1'b1;
        end
        else
        begin
            // type nibble high, version bit in bit 0 over the fixed low code
            r.code = CODE_LOW | {g.b[15:12], 4'h0} | {7'h00, g.b[11]};
            if (g.b[15:12] == TYPE_NAME)
            begin
                // 0a and 0b both carry a name pair in block d
                pos = {g.b[1:0], 1'b0};
                hi  = g.d[15:8];
                lo  = g.d[7:0];
                if (cand_name[pos] == hi && cand_name[pos + 1] == lo)
                begin
                    conf_name[pos]     = hi;
                    conf_name[pos + 1] = lo;
                    if (g.b[1:0] == LAST_SEGMENT)
                    begin
                        // full eight byte compare, zero bytes included
                        same        = 1'b1;
                        packed_name = '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            if (cand_name[i] != conf_name[i])
                                same = 1'b0;
                            packed_name = {packed_name[55:0], conf_name[i]};
                        end
                        if (same && packed_name != pub_name)
                        begin
                            pub_name  = packed_name;
                            r.changed = 1'b1;
                        end
                    end
                end
                cand_name[pos]     = hi;
                cand_name[pos + 1] = lo;
            end
            else if (g.b[15:12] == TYPE_TEXT && !g.b[11])
            begin
                // version a text group; a flipped a/b flag clears the text first
                if (g.b[4] != text_flag)
                begin
                    text_flag = g.b[4];
                    r.cleared = 1'b1;
                end
                r.written = 1'b1;
                r.slot    = g.b[3:0];
                r.chars   = {g.c, g.d};
            end
        end
        r.name = pub_name;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic enqueue(input logic [15:0] a, input logic [15:0] b,
                           input logic [15:0] c, input logic [15:0] d);
        rds_group_t g;
        g = {a, b, c, d};
        group_backlog.push_back(g);
    endtask

    function automatic logic [15:0] pi_code();
        return 16'($urandom_range(1, 65535));
    endfunction

    // name group for one segment; block_b bits 10..2 carry random junk
    task automatic enqueue_pair(input logic [63:0] nm, input logic ver, input int seg);
        logic [15:0] b;
        b = {TYPE_NAME, ver, 9'($urandom), 2'(seg)};
        enqueue(pi_code(), b, 16'($urandom), nm[63 - 16 * seg -: 16]);
    endtask

    task automatic enqueue_text(input logic flag, input logic [3:0] slot,
                                input logic [15:0] c, input logic [15:0] d);
        enqueue(pi_code(), {TYPE_TEXT, 1'b0, 6'($urandom), flag, slot}, c, d);
    endtask

    function automatic logic [63:0] random_name(input bit with_zeros);
        logic [63:0] nm;
        int          pick;
        nm = '0;
        for (int i = 0; i < 8; i++)
        begin
            pick = $urandom_range(0, 9);
            if (with_zeros && pick < 3)
                nm = {nm[55:0], 8'h00};
            else if (pick == 9)
                nm = {nm[55:0], 8'($urandom)};
            else
                nm = {nm[55:0], 8'($urandom_range(32, 126))};
        end
        return nm;
    endfunction

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [63:0] name_pool [6];
        logic [63:0] nm;
        logic        ver;
        int          pick;
        int          mode;

        // --- directed part ---
        enqueue(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);          // reset group
        enqueue_text(1'b0, 4'h0, 16'h0000, 16'h0000);              // same flag, no clear
        // name with zero bytes sent twice in order publishes on the last pair
        nm = {"KX", 8'h00, 8'h00, " FM", 8'hFF};
        for (int p = 0; p < 2; p++)
            for (int s = 0; s < 4; s++)
                enqueue_pair(nm, 1'b0, s);
        enqueue_text(1'b1, 4'hF, 16'hFFFF, 16'hFFFF);              // flag toggle clears
        enqueue_text(1'b1, 4'h9, 16'h4142, 16'h4344);
        enqueue(16'hFFFF, {TYPE_TEXT, 1'b1, 11'h7FF}, 16'hFFFF, 16'hFFFF);  // 2b is ignored
        enqueue(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);          // type 15 version b
        enqueue(16'h0000, 16'h0000, 16'h0000, 16'h0000);          // reset again
        // dashes match the reset candidate, so one pass confirms and publishes
        for (int s = 0; s < 4; s++)
            enqueue_pair({8{CHAR_DASH}}, 1'b1, s);
        enqueue_pair({8{CHAR_DASH}}, 1'b1, 3);                     // same name, no change
        enqueue_text(1'b1, 4'h3, 16'h2020, 16'h2020);              // flag kept over reset
        stim_flag = 1'b1;

        // --- random part ---
        name_pool[0] = random_name(1'b0);
        name_pool[1] = random_name(1'b0);
        name_pool[2] = random_name(1'b1);
        name_pool[3] = random_name(1'b1);
        name_pool[4] = {8{CHAR_DASH}};
        name_pool[5] = NAME_SPACES;
        while (group_backlog.size() < GROUP_COUNT)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // name broadcast of a pool or fresh name, in order or with corrupted, doubled or shuffled pairs
                nm   = name_pool[$urandom_range(0, 5)];
                ver  = 1'($urandom);
                mode = $urandom_range(0, 7);
                if (mode == 0)
                    nm = random_name(1'($urandom));
                for (int p = 0; p < 2; p++)
                    for (int s = 0; s < 4; s++)
                    begin
                        if (mode == 1 && $urandom_range(0, 3) == 0)
                            // broken sequence: a corrupted pair
                            enqueue_pair(random_name(1'b0), ver, s);
                        else if (mode == 2)
                            // each pair repeated back to back
                            begin
                                if (p == 0)
                                begin
                                    enqueue_pair(nm, ver, s);
                                    enqueue_pair(nm, ver, s);
                                end
                            end
                        else if (mode == 3)
                            enqueue_pair(nm, ver, $urandom_range(0, 3));
                        else
                            enqueue_pair(nm, ver, s);
                    end
            end
            else if (pick < 72)
            begin
                if ($urandom_range(0, 4) == 0)
                    stim_flag = ~stim_flag;
                enqueue_text(stim_flag, 4'($urandom), 16'($urandom), 16'($urandom));
            end
            else if (pick < 76)
                enqueue(16'h0000, 16'($urandom), 16'($urandom), 16'($urandom));
            else
                enqueue(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        total_groups = group_backlog.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted < total_groups || decoded_due.size() != 0)
            @(posedge clk);
        // keep the clock running to catch any stray result
        repeat (20) @(posedge clk);
        #1;
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // predictor stores start from the block's reset values
    initial
    begin
        for (int i = 0; i < 8; i++)
        begin
            cand_name[i] = CHAR_DASH;
            conf_name[i] = CHAR_DASH;
        end
        pub_name  = NAME_SPACES;
        text_flag = 1'b0;
    end

    // ------------------------------------------------------------------
    // driver: offers backlog groups, predicts each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        rds_group_t nxt;
        logic       offer;
        if (!rst_n)
        begin
            grp_valid <= 1'b0;
        end
        else
        begin
            offer = grp_valid;
            if (grp_valid && !grp_stall)
            begin
                decoded_due.push_back(decode_group({block_a, block_b, block_c, block_d}));
                accepted <= accepted + 1;
                offer = 1'b0;
                // gap bursts only in alternate stretches and never in the tail
                if (accepted < total_groups - CALM_TAIL && cycles[9]
                    && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 9);
            end
            if (!offer)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (group_backlog.size() != 0)
                begin
                    nxt     = group_backlog.pop_front();
                    block_a <= nxt.a;
                    block_b <= nxt.b;
                    block_c <= nxt.c;
                    block_d <= nxt.d;
                    offer   = 1'b1;
                end
            end
            // single assignment per edge, valid stays up across back to back items
            grp_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // receiver stall: one long hold to back the block up, plus random bursts
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : receiver
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else if (results_seen < total_groups - CALM_TAIL && cycles[8]
                     && $urandom_range(0, 4) == 0)
            begin
                // this cycle opens a stall burst whose further length is drawn at random
                stall_left = $urandom_range(0, 8);
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares each taken result against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            faults++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        decoded_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen <= results_seen + 1;
            if (decoded_due.size() == 0)
            begin
                $error("result item with nothing expected, group_code %0h", group_code);
                faults++;
            end
            else
            begin
                want = decoded_due.pop_front();
                check_field("group_code", 64'(want.code), 64'(group_code));
                check_field("station_name", want.name, station_name);
                check_field("name_changed", 64'(want.changed), 64'(name_changed));
                check_field("was_reset", 64'(want.reset), 64'(was_reset));
                check_field("text_cleared", 64'(want.cleared), 64'(text_cleared));
                check_field("text_written", 64'(want.written), 64'(text_written));
                check_field("text_slot", 64'(want.slot), 64'(text_slot));
                check_field("text_chars", 64'(want.chars), 64'(text_chars));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
